@@ hdl/assert_macros.svh @@
// assertion macros shared by the rtl files of the ordered key list
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define OKL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define OKL_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define OKL_ASSERT(label, clk, rst_n, prop, msg)
`define OKL_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

@@ hdl/okl_pkg.sv @@
// constants, status codes and control structs of the ordered key list
// used by okl_free and ordered_key_list_with_slot_pool; no dependencies
package okl_pkg;

    localparam int SLOTS      = 32;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int PTR_W      = $clog2(SLOTS + 2);
    localparam int STEP_W     = $clog2(SLOTS + 1);
    localparam int ROW_W      = 4;
    localparam int COL_W      = 4;
    localparam int KIND_W     = 3;
    localparam int KEY_W      = ROW_W + COL_W + KIND_W;
    localparam int STATUS_W   = 3;
    localparam int OUT_SLOT_W = 5;
    localparam int HEAD_W     = 6;
    localparam int IN_DATA_W  = ((KEY_W + 7) / 8) * 8;
    localparam int OUT_BITS   = OUT_SLOT_W + 2 * HEAD_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // link value that marks the last entry, also the empty-list head/tail
    localparam logic [PTR_W-1:0] END_MARK = PTR_W'(SLOTS);

    typedef enum logic [0:0] {
        REQ_ADD    = 1'b0,
        REQ_REMOVE = 1'b1
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ADDED     = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_REMOVED   = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic              start;
        logic              alloc;
        logic              release_slot;
        logic [SLOT_W-1:0] slot;
    } free_ctrl_t;

    typedef struct packed {
        logic              done;
        logic              full;
        logic [SLOT_W-1:0] slot;
    } free_stat_t;

endpackage

@@ hdl/okl_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module okl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/okl_free.sv @@
// free slot bitmap with a one-slot-per-cycle lowest-free scanner
// depends on okl_pkg
module okl_free (
    input  logic               clk,
    input  logic               rst_n,
    input  okl_pkg::free_ctrl_t ctrl,
    output okl_pkg::free_stat_t stat
);

    logic [okl_pkg::SLOTS-1:0]  free_reg, free_next;
    logic [okl_pkg::SLOT_W-1:0] idx_reg, idx_next;
    logic                       busy_reg, busy_next;
    logic                       hit;
    logic                       last;

    assign hit  = free_reg[idx_reg];
    assign last = (idx_reg == okl_pkg::SLOT_W'(okl_pkg::SLOTS - 1));

    always_comb
    begin
        stat.done = busy_reg && (hit || last);
        stat.full = !hit;
        stat.slot = idx_reg;
    end

    always_comb
    begin
        free_next = free_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (ctrl.alloc)
        begin
            free_next[ctrl.slot] = 1'b0;
        end
        if (ctrl.release_slot)
        begin
            free_next[ctrl.slot] = 1'b1;
        end
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (busy_reg)
        begin
            if (hit || last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + okl_pkg::SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '1;
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            free_reg <= free_next;
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

endmodule

@@ hdl/ordered_key_list_with_slot_pool.sv @@
// top level of the ordered key list: request sequencer, key and link rams
// depends on okl_pkg, okl_ram, okl_free and assert_macros.svh
//
// usage
//   s_* carries requests: s_tuser is the request (0 add, 1 remove), s_tdata the key.
//   m_* carries one result word per request: status on m_tuser, slots on m_tdata.
//   a word is taken on a cycle where tvalid and tready are both high.
// sequencing
//   one request at a time. a list walk reads key and link ram at the current
//   slot and compares on the next cycle, once per visited entry.
//   an add that misses scans the free bitmap one slot per cycle (up to 32 slots),
//   then links a free slot in S_APPEND1 and S_APPEND2; a remove unlinks in S_UNLINK.
//   the result word is loaded into the output register from S_DONE.
// reset
//   the list is empty, all slots free; no clearing pass is needed.
// back-pressure
//   the result sits in an output register; s_tready returns once the result is
//   loaded, and a new request may run while the last word waits. a finished
//   request holds in its final state until the output register is free.
`include "assert_macros.svh"

module ordered_key_list_with_slot_pool (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [okl_pkg::IN_DATA_W-1:0]      s_tdata,  // key_row, key_col, key_kind, pad
    input  logic                               s_tuser,  // req_type
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [okl_pkg::OUT_DATA_W-1:0]     m_tdata,  // slot, head_slot, tail_slot, pad
    output logic [okl_pkg::STATUS_W-1:0]       m_tuser   // status
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_WALK_RD  = 9'b000000010,
        S_WALK_CMP = 9'b000000100,
        S_RESOLVE  = 9'b000001000,
        S_SCAN     = 9'b000010000,
        S_APPEND1  = 9'b000100000,
        S_APPEND2  = 9'b001000000,
        S_UNLINK   = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    state_t                      state_reg, state_next;
    logic [okl_pkg::PTR_W-1:0]   head_reg, head_next;
    logic [okl_pkg::PTR_W-1:0]   tail_reg, tail_next;
    logic                        out_valid_reg, out_valid_next;

    okl_pkg::req_t               req_reg, req_next;
    logic [okl_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [okl_pkg::PTR_W-1:0]   cur_reg, cur_next;
    logic [okl_pkg::PTR_W-1:0]   prev_reg, prev_next;
    logic [okl_pkg::STEP_W-1:0]  steps_reg, steps_next;
    logic                        found_reg, found_next;
    logic [okl_pkg::SLOT_W-1:0]  found_slot_reg, found_slot_next;
    logic [okl_pkg::PTR_W-1:0]   nxt_reg, nxt_next;
    logic [okl_pkg::SLOT_W-1:0]  new_slot_reg, new_slot_next;
    okl_pkg::status_t            status_reg, status_next;
    logic [okl_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    okl_pkg::status_t            out_status_reg, out_status_next;
    logic [okl_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                        key_we;
    logic [okl_pkg::SLOT_W-1:0]  key_waddr;
    logic [okl_pkg::KEY_W-1:0]   key_rdata;
    logic                        link_we;
    logic [okl_pkg::SLOT_W-1:0]  link_waddr;
    logic [okl_pkg::PTR_W-1:0]   link_wdata;
    logic [okl_pkg::PTR_W-1:0]   link_rdata;
    logic [okl_pkg::STEP_W-1:0]  steps_inc;
    logic                        in_take;
    logic                        out_free;

    okl_pkg::free_ctrl_t         free_ctrl;
    okl_pkg::free_stat_t         free_stat;

    okl_ram #(.WIDTH(okl_pkg::KEY_W), .DEPTH(okl_pkg::SLOTS)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_reg),
        .raddr (cur_reg[okl_pkg::SLOT_W-1:0]),
        .rdata (key_rdata)
    );

    okl_ram #(.WIDTH(okl_pkg::PTR_W), .DEPTH(okl_pkg::SLOTS)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (cur_reg[okl_pkg::SLOT_W-1:0]),
        .rdata (link_rdata)
    );

    okl_free u_free (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (free_ctrl),
        .stat  (free_stat)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign in_take   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign steps_inc = steps_reg + okl_pkg::STEP_W'(1);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        out_valid_next  = out_valid_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        steps_next      = steps_reg;
        found_next      = found_reg;
        found_slot_next = found_slot_reg;
        nxt_next        = nxt_reg;
        new_slot_next   = new_slot_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        key_we          = 1'b0;
        key_waddr       = new_slot_reg;
        link_we         = 1'b0;
        link_waddr      = new_slot_reg;
        link_wdata      = okl_pkg::END_MARK;
        free_ctrl       = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    req_next   = okl_pkg::req_t'(s_tuser);
                    // key is row, col, kind from high to low bits
                    key_next   = {s_tdata[3:0], s_tdata[7:4], s_tdata[10:8]};
                    cur_next   = head_reg;
                    prev_next  = okl_pkg::END_MARK;
                    steps_next = '0;
                    found_next = 1'b0;
                    state_next = (head_reg < okl_pkg::END_MARK) ? S_WALK_RD : S_RESOLVE;
                end
            end
            S_WALK_RD:
            begin
                state_next = S_WALK_CMP;
            end
            S_WALK_CMP:
            begin
                if (key_rdata == key_reg)
                begin
                    found_next      = 1'b1;
                    found_slot_next = cur_reg[okl_pkg::SLOT_W-1:0];
                    nxt_next        = (link_rdata >= okl_pkg::END_MARK) ?
                                      okl_pkg::END_MARK : link_rdata;
                    state_next      = S_RESOLVE;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_rdata;
                    steps_next = steps_inc;
                    if (link_rdata >= okl_pkg::END_MARK ||
                        steps_inc == okl_pkg::STEP_W'(okl_pkg::SLOTS))
                    begin
                        state_next = S_RESOLVE;
                    end
                    else
                    begin
                        state_next = S_WALK_RD;
                    end
                end
            end
            S_RESOLVE:
            begin
                if (req_reg == okl_pkg::REQ_ADD)
                begin
                    if (found_reg)
                    begin
                        status_next = okl_pkg::STAT_DUPLICATE;
                        slot_next   = found_slot_reg;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        free_ctrl.start = 1'b1;
                        state_next      = S_SCAN;
                    end
                end
                else if (found_reg)
                begin
                    state_next = S_UNLINK;
                end
                else
                begin
                    status_next = okl_pkg::STAT_NOT_FOUND;
                    slot_next   = '0;
                    state_next  = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (free_stat.done)
                begin
                    if (free_stat.full)
                    begin
                        status_next = okl_pkg::STAT_FULL;
                        slot_next   = '0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        new_slot_next = free_stat.slot;
                        state_next    = S_APPEND1;
                    end
                end
            end
            S_APPEND1:
            begin
                key_we    = 1'b1;
                key_waddr = new_slot_reg;
                if (head_reg < okl_pkg::END_MARK && tail_reg < okl_pkg::END_MARK)
                begin
                    link_we    = 1'b1;
                    link_waddr = tail_reg[okl_pkg::SLOT_W-1:0];
                    link_wdata = okl_pkg::PTR_W'(new_slot_reg);
                end
                else
                begin
                    head_next = okl_pkg::PTR_W'(new_slot_reg);
                end
                // on an empty list head and tail move on the same edge
                tail_next  = okl_pkg::PTR_W'(new_slot_reg);
                state_next = S_APPEND2;
            end
            S_APPEND2:
            begin
                link_we         = 1'b1;
                link_waddr      = new_slot_reg;
                link_wdata      = okl_pkg::END_MARK;
                free_ctrl.alloc = 1'b1;
                free_ctrl.slot  = new_slot_reg;
                status_next     = okl_pkg::STAT_ADDED;
                slot_next       = new_slot_reg;
                state_next      = S_DONE;
            end
            S_UNLINK:
            begin
                if (prev_reg < okl_pkg::END_MARK)
                begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg[okl_pkg::SLOT_W-1:0];
                    link_wdata = nxt_reg;
                end
                else
                begin
                    head_next = nxt_reg;
                end
                if (okl_pkg::PTR_W'(found_slot_reg) == tail_reg)
                begin
                    tail_next = prev_reg;
                end
                free_ctrl.release_slot = 1'b1;
                free_ctrl.slot         = found_slot_reg;
                status_next            = okl_pkg::STAT_REMOVED;
                slot_next              = found_slot_reg;
                state_next             = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_data_next   = okl_pkg::OUT_DATA_W'({
                        tail_reg[okl_pkg::HEAD_W-1:0],
                        head_reg[okl_pkg::HEAD_W-1:0],
                        okl_pkg::OUT_SLOT_W'(slot_reg)});
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= okl_pkg::END_MARK;
            tail_reg      <= okl_pkg::END_MARK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        key_reg        <= key_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        steps_reg      <= steps_next;
        found_reg      <= found_next;
        found_slot_reg <= found_slot_next;
        nxt_reg        <= nxt_next;
        new_slot_reg   <= new_slot_next;
        status_reg     <= status_next;
        slot_reg       <= slot_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
    end

    // head and tail are either both the end mark or both real slots
    `OKL_ASSERT(a_head_tail_empty, clk, rst_n, ((head_reg == okl_pkg::END_MARK) == (tail_reg == okl_pkg::END_MARK)), "head and tail disagree on empty list")
    // a taken request keeps the input closed on the next cycle
    `OKL_ASSERT(a_one_at_a_time, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready, "request accepted while busy")
    // a new result word only comes out of the final state
    `OKL_ASSERT(a_word_from_done, clk, rst_n, (!$past(out_valid_reg) && out_valid_reg) |-> ($past(state_reg) == S_DONE), "result word without a finished request")

endmodule
